FILE: rtl/core/c8_pkg.sv
// Shared constants and types for the CHIP-8 instruction core.
`timescale 1ns / 1ps
package c8_pkg;

  localparam int MEM_DEPTH   = 4096;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int SCREEN_ROWS = 32;
  localparam int ROW_W       = $clog2(SCREEN_ROWS);
  localparam int SCREEN_COLS = 64;
  localparam int COL_W       = $clog2(SCREEN_COLS);

  localparam logic [ADDR_W-1:0] PC_START    = 12'h200;
  localparam logic [7:0]        TIMER_RESET = 8'd60;

  localparam logic [2:0] OP_EXEC  = 3'd0;
  localparam logic [2:0] OP_TICK  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_ROW   = 3'd4;

  typedef struct packed {
    logic                   clr;
    logic                   we;
    logic [ROW_W-1:0]       addr;
    logic [SCREEN_COLS-1:0] wdata;
  } frame_ctrl_t;

endpackage

FILE: rtl/core/c8_mem.sv
// Main memory: single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module c8_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [c8_pkg::ADDR_W-1:0] addr_i,
  input  logic [7:0]                wdata_i,
  output logic [7:0]                rdata_o
);

  logic [7:0] mem_q [c8_pkg::MEM_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: rtl/core/c8_frame.sv
// Display frame store: 32 rows of 64 pixels with clear and row write.
`timescale 1ns / 1ps
module c8_frame (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  c8_pkg::frame_ctrl_t            ctrl_i,
  input  logic [c8_pkg::ROW_W-1:0]       raddr_i,
  output logic [c8_pkg::SCREEN_COLS-1:0] rdata_o
);

  logic [c8_pkg::SCREEN_COLS-1:0] rows_q [c8_pkg::SCREEN_ROWS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < c8_pkg::SCREEN_ROWS; r++) begin
        rows_q[r] <= '0;
      end
    end else if (ctrl_i.clr) begin
      for (int r = 0; r < c8_pkg::SCREEN_ROWS; r++) begin
        rows_q[r] <= '0;
      end
    end else if (ctrl_i.we) begin
      rows_q[ctrl_i.addr] <= ctrl_i.wdata;
    end
  end

  assign rdata_o = rows_q[raddr_i];

endmodule

FILE: rtl/core/chip8_instruction_core_unit.sv
// Top level of the CHIP-8 instruction core: sequencer, registers and result stage.
`timescale 1ns / 1ps
// Usage:
//   Requests enter on in_valid_i/in_ready_o with op, address, write byte, row
//   index, key bitmap and random byte. Each request yields exactly one result
//   on out_valid_o/out_ready_i. font_base is written through cfg_we_i with
//   cfg_wdata_i; the user must do this only while the core is idle, as the
//   core does not enforce it. The sequencer walks the single-port memory and
//   one-read register file: tick, write, row read and unused ops go straight
//   to the final state, memory read via a read state, execute via opcode fetch,
//   decode and VX/VY reads; DXYN, FX55 and FX65 then loop over rows or registers.
//   One request is in flight at a time; in_ready_o is high only when idle.
//   The next request is taken while the previous result still waits in the
//   output register; if the receiver stalls, a finished request holds in the
//   final state until the output register frees.
//   Reset (rst_ni low, asynchronous) sets PC to 0x200, index, stack pointer,
//   registers and display to zero, both timers to 60 and font_base to zero.
//   Main memory and call stack hold no reset value.
module chip8_instruction_core_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  write_byte_i,
  input  logic [4:0]  row_index_i,
  input  logic [15:0] key_state_i,
  input  logic [7:0]  random_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_byte_o,
  output logic [63:0] row_bits_o,
  output logic [11:0] pc_now_o,
  output logic        sound_on_o,
  output logic        key_wait_o
);

  localparam int AW = c8_pkg::ADDR_W;
  localparam int SW = c8_pkg::SP_W;

  // Sequencer state codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RDMEM   = 4'd1;
  localparam logic [3:0] S_F_HI    = 4'd2;
  localparam logic [3:0] S_F_LO    = 4'd3;
  localparam logic [3:0] S_DEC     = 4'd4;
  localparam logic [3:0] S_RX      = 4'd5;
  localparam logic [3:0] S_RY      = 4'd6;
  localparam logic [3:0] S_EXEC    = 4'd7;
  localparam logic [3:0] S_DRAW_RD = 4'd8;
  localparam logic [3:0] S_DRAW_WR = 4'd9;
  localparam logic [3:0] S_ST      = 4'd10;
  localparam logic [3:0] S_LD_RD   = 4'd11;
  localparam logic [3:0] S_LD_WR   = 4'd12;
  localparam logic [3:0] S_FIN     = 4'd13;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] pc_q, idx_q, font_q;
  logic [SW-1:0] sp_q, sp_inc, sp_dec;
  logic [7:0]    dly_q, snd_q;
  logic [7:0]    regs_q [16];
  logic [AW-1:0] stack_q [c8_pkg::STACK_DEPTH];
  logic [15:0]   opc_q;
  logic [7:0]    hi_q, vx_q, vy_q, rnd_q;
  logic [15:0]   keys_q;
  logic [3:0]    cnt_q;
  logic          erased_q;
  logic [7:0]    res_rd_q;
  logic [63:0]   res_row_q;
  logic          wait_q;
  logic          out_valid_q;
  logic [7:0]    read_byte_q;
  logic [63:0]   row_bits_q;
  logic [AW-1:0] pc_now_q;
  logic          sound_on_q, key_wait_q;

  logic accept, out_free;
  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Opcode fields
  logic [3:0]    nib, xa, ya, na;
  logic [7:0]    nn;
  logic [AW-1:0] nnn;
  assign nib = opc_q[15:12];
  assign xa  = opc_q[11:8];
  assign ya  = opc_q[7:4];
  assign na  = opc_q[3:0];
  assign nn  = opc_q[7:0];
  assign nnn = opc_q[11:0];

  assign sp_inc = (sp_q == SW'(c8_pkg::STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
  assign sp_dec = (sp_q == '0) ? SW'(c8_pkg::STACK_DEPTH - 1) : sp_q - 1'b1;

  // Register file read port: one address per cycle
  logic [3:0] rf_raddr;
  logic [7:0] rf_rdata;
  always_comb begin
    case (state_q)
      S_RX:    rf_raddr = xa;
      S_RY:    rf_raddr = (nib == 4'hB) ? 4'h0 : ya;
      default: rf_raddr = cnt_q;
    endcase
  end
  assign rf_rdata = regs_q[rf_raddr];

  // Main memory port
  logic          mem_we;
  logic [AW-1:0] mem_addr, blk_addr;
  logic [7:0]    mem_wdata, mem_rdata;
  assign blk_addr = idx_q + {{(AW-4){1'b0}}, cnt_q};

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rf_rdata;
    case (state_q)
      S_IDLE: begin
        mem_addr  = address_i;
        mem_we    = accept && (op_i == c8_pkg::OP_WRITE);
        mem_wdata = write_byte_i;
      end
      S_F_HI:             mem_addr = pc_q;
      S_F_LO:             mem_addr = pc_q + 1'b1;
      S_DRAW_RD, S_LD_RD: mem_addr = blk_addr;
      S_ST: begin
        mem_addr = blk_addr;
        mem_we   = 1'b1;
      end
      default:            mem_addr = pc_q;
    endcase
  end

  c8_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Sprite row: rotate the sprite byte into place, each pixel wraps on its own
  logic [c8_pkg::ROW_W-1:0] draw_row;
  logic [127:0]             rot_wide;
  logic [63:0]              draw_mask, frame_rdata;
  logic                     draw_hit, erased_n, draw_last;
  c8_pkg::frame_ctrl_t      frame_ctrl;

  assign draw_row  = vy_q[c8_pkg::ROW_W-1:0] + {1'b0, cnt_q};
  assign rot_wide  = {mem_rdata, 56'b0, mem_rdata, 56'b0} >> vx_q[c8_pkg::COL_W-1:0];
  assign draw_mask = rot_wide[63:0];
  assign draw_hit  = |(frame_rdata & draw_mask);
  assign erased_n  = erased_q | draw_hit;
  assign draw_last = ({1'b0, cnt_q} + 5'd1) == {1'b0, na};

  always_comb begin
    frame_ctrl.clr   = (state_q == S_EXEC) && (nib == 4'h0) && (nn == 8'hE0);
    frame_ctrl.we    = (state_q == S_DRAW_WR);
    frame_ctrl.addr  = draw_row;
    frame_ctrl.wdata = frame_rdata ^ draw_mask;
  end

  c8_frame u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (frame_ctrl),
    .raddr_i ((state_q == S_IDLE) ? row_index_i : draw_row),
    .rdata_o (frame_rdata)
  );

  // Key helpers
  logic       key_dn, any_key;
  logic [3:0] key_num;
  assign key_dn  = (vx_q[7:4] == 4'h0) && keys_q[vx_q[3:0]];
  assign any_key = |keys_q;
  always_comb begin
    key_num = 4'h0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_q[k]) begin
        key_num = 4'(k);
      end
    end
  end

  logic [8:0]    sum9;
  logic [AW-1:0] pc_skip, five_vx;
  assign sum9    = {1'b0, vx_q} + {1'b0, vy_q};
  assign pc_skip = pc_q + 12'd2;
  assign five_vx = {2'b0, vx_q, 2'b0} + {4'b0, vx_q};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_i == c8_pkg::OP_EXEC) begin
            state_d = S_F_HI;
          end else if (op_i == c8_pkg::OP_READ) begin
            state_d = S_RDMEM;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_RDMEM:   state_d = S_FIN;
      S_F_HI:    state_d = S_F_LO;
      S_F_LO:    state_d = S_DEC;
      S_DEC:     state_d = S_RX;
      S_RX:      state_d = S_RY;
      S_RY:      state_d = S_EXEC;
      S_EXEC: begin
        if (nib == 4'hD) begin
          state_d = (na == 4'h0) ? S_FIN : S_DRAW_RD;
        end else if (nib == 4'hF && nn == 8'h55) begin
          state_d = S_ST;
        end else if (nib == 4'hF && nn == 8'h65) begin
          state_d = S_LD_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DRAW_RD: state_d = S_DRAW_WR;
      S_DRAW_WR: state_d = draw_last ? S_FIN : S_DRAW_RD;
      S_ST:      state_d = (cnt_q == xa) ? S_FIN : S_ST;
      S_LD_RD:   state_d = S_LD_WR;
      S_LD_WR:   state_d = (cnt_q == xa) ? S_FIN : S_LD_RD;
      S_FIN:     state_d = out_free ? S_IDLE : S_FIN;
      default:   state_d = S_IDLE;
    endcase
  end

  // Control state and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= c8_pkg::PC_START;
      idx_q       <= '0;
      font_q      <= '0;
      sp_q        <= '0;
      dly_q       <= c8_pkg::TIMER_RESET;
      snd_q       <= c8_pkg::TIMER_RESET;
      cnt_q       <= '0;
      erased_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < 16; r++) begin
        regs_q[r] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        font_q <= cfg_wdata_i;
      end
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (accept && op_i == c8_pkg::OP_TICK) begin
            if (dly_q != 8'd0) dly_q <= dly_q - 1'b1;
            if (snd_q != 8'd0) snd_q <= snd_q - 1'b1;
          end
        end
        S_DEC: pc_q <= pc_q + 12'd2;
        S_EXEC: begin
          cnt_q    <= '0;
          erased_q <= 1'b0;
          case (nib)
            4'h0: begin
              if (nn == 8'hEE) begin
                sp_q <= sp_dec;
                pc_q <= stack_q[sp_dec];
              end
            end
            4'h1: pc_q <= nnn;
            4'h2: begin
              sp_q <= sp_inc;
              pc_q <= nnn;
            end
            4'h3: if (vx_q == nn) pc_q <= pc_skip;
            4'h4: if (vx_q != nn) pc_q <= pc_skip;
            4'h5: if (vx_q == vy_q) pc_q <= pc_skip;
            4'h6: regs_q[xa] <= nn;
            4'h7: regs_q[xa] <= vx_q + nn;
            4'h8: begin
              case (na)
                4'h0: regs_q[xa] <= vy_q;
                4'h1: regs_q[xa] <= vx_q | vy_q;
                4'h2: regs_q[xa] <= vx_q & vy_q;
                4'h3: regs_q[xa] <= vx_q ^ vy_q;
                4'h4: begin
                  regs_q[xa] <= sum9[7:0];
                  regs_q[15] <= {7'b0, sum9[8]};
                end
                4'h5: begin
                  regs_q[xa] <= vx_q - vy_q;
                  regs_q[15] <= {7'b0, vx_q >= vy_q};
                end
                4'h6: begin
                  regs_q[xa] <= {1'b0, vx_q[7:1]};
                  regs_q[15] <= {7'b0, vx_q[0]};
                end
                4'h7: begin
                  regs_q[xa] <= vy_q - vx_q;
                  regs_q[15] <= {7'b0, vy_q >= vx_q};
                end
                4'hE: begin
                  regs_q[xa] <= {vx_q[6:0], 1'b0};
                  regs_q[15] <= {7'b0, vx_q[7]};
                end
                default: ;
              endcase
            end
            4'h9: if (vx_q != vy_q) pc_q <= pc_skip;
            4'hA: idx_q <= nnn;
            4'hB: pc_q <= nnn + {4'b0, vy_q};
            4'hC: regs_q[xa] <= rnd_q & nn;
            4'hD: regs_q[15] <= 8'd0;
            4'hE: begin
              if (nn == 8'h9E && key_dn) begin
                pc_q <= pc_skip;
              end else if (nn == 8'hA1 && !key_dn) begin
                pc_q <= pc_skip;
              end
            end
            default: begin
              case (nn)
                8'h07: regs_q[xa] <= dly_q;
                8'h0A: begin
                  if (any_key) begin
                    regs_q[xa] <= {4'b0, key_num};
                  end else begin
                    pc_q <= pc_q - 12'd2;
                  end
                end
                8'h15: dly_q <= vx_q;
                8'h18: snd_q <= vx_q;
                8'h1E: idx_q <= idx_q + {4'b0, vx_q};
                8'h29: idx_q <= font_q + five_vx;
                default: ;
              endcase
            end
          endcase
        end
        S_DRAW_WR: begin
          erased_q <= erased_n;
          if (draw_last) begin
            regs_q[15] <= {7'b0, erased_n};
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_ST: if (cnt_q != xa) cnt_q <= cnt_q + 1'b1;
        S_LD_WR: begin
          regs_q[cnt_q] <= mem_rdata;
          if (cnt_q != xa) cnt_q <= cnt_q + 1'b1;
        end
        default: ;
      endcase
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload, opcode and call stack (no reset)
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          keys_q    <= key_state_i;
          rnd_q     <= random_byte_i;
          res_rd_q  <= '0;
          wait_q    <= 1'b0;
          res_row_q <= (op_i == c8_pkg::OP_ROW) ? frame_rdata : '0;
        end
      end
      S_RDMEM: res_rd_q <= mem_rdata;
      S_F_LO:  hi_q <= mem_rdata;
      S_DEC:   opc_q <= {hi_q, mem_rdata};
      S_RX:    vx_q <= rf_rdata;
      S_RY:    vy_q <= rf_rdata;
      S_EXEC: begin
        if (nib == 4'h2) begin
          stack_q[sp_q] <= pc_q;
        end
        if (nib == 4'hF && nn == 8'h0A && !any_key) begin
          wait_q <= 1'b1;
        end
      end
      default: ;
    endcase
    if (state_q == S_FIN && out_free) begin
      read_byte_q <= res_rd_q;
      row_bits_q  <= res_row_q;
      pc_now_q    <= pc_q;
      sound_on_q  <= (snd_q != 8'd0);
      key_wait_q  <= wait_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_byte_o = read_byte_q;
  assign row_bits_o  = row_bits_q;
  assign pc_now_o    = pc_now_q;
  assign sound_on_o  = sound_on_q;
  assign key_wait_o  = key_wait_q;

  // Every accepted request leaves idle on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("core stayed idle after accepting a request");

  // A sprite row write always follows its memory read
  a_draw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAW_WR) |-> ($past(state_q) == S_DRAW_RD))
    else $error("sprite row write without preceding read");

  // A key wait result comes only from execute, so no read data rides along
  a_wait_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && key_wait_o) |-> (read_byte_o == 8'd0 && row_bits_o == 64'd0))
    else $error("key wait result carries read data");

endmodule
